### rtl/core/z2n_pkg.sv
// Shared types, constants and the quarter-wave sine table of the Z^2_n accumulator.
// No dependencies; every other file of the block imports this package.
`timescale 1ns / 1ps
package z2n_pkg;

  localparam int NUM_TRIALS      = 256;
  localparam int MAX_HARMONICS   = 8;
  localparam int PHASE_BITS      = 16;
  localparam int SINE_TABLE_BITS = 10;
  localparam int COUNT_BITS      = 20;

  localparam int TRIAL_W   = 8;
  localparam int TRIAL_AW  = $clog2(NUM_TRIALS);
  localparam int HK_W      = $clog2(MAX_HARMONICS);
  localparam int SLOT_W    = TRIAL_AW + HK_W;
  localparam int NUM_SLOTS = NUM_TRIALS * MAX_HARMONICS;
  localparam int HN_W      = 4;
  localparam int IDX_W     = SINE_TABLE_BITS + 2;
  localparam int QTR       = 1 << SINE_TABLE_BITS;
  localparam int HALF_QTR  = QTR / 2;
  localparam int QA_W      = SINE_TABLE_BITS + 1;
  localparam int SIN_W     = 16;
  localparam int SUM_W     = 36;
  localparam int HALF_W    = SUM_W / 2;
  localparam int ACC_W     = 2 * SUM_W;
  localparam int POW_SHIFT = 21;
  localparam int DVD_W     = ACC_W - POW_SHIFT - 1;
  localparam int DSTEP_W   = $clog2(DVD_W);
  localparam int REM_W     = COUNT_BITS + 1;
  localparam int POW_W     = 40;

  localparam logic OP_ADD   = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  localparam logic [HN_W-1:0] HARM_RESET = 4'd2;

  typedef struct packed {
    logic                  opcode;
    logic [TRIAL_W-1:0]    trial_index;
    logic [PHASE_BITS-1:0] phase;
  } in_req_t;

  typedef struct packed {
    logic [HN_W-1:0]       harmonic_number;
    logic [POW_W-1:0]      harmonic_power;
    logic [POW_W-1:0]      cumulative_power;
    logic [COUNT_BITS-1:0] event_count;
    logic                  no_events;
    logic                  last;
  } out_rsp_t;

  typedef struct packed {
    logic                    start;
    logic signed [SUM_W-1:0] sin_sum;
    logic signed [SUM_W-1:0] cos_sum;
    logic [COUNT_BITS-1:0]   count;
  } pw_req_t;

  typedef struct packed {
    logic             done;
    logic [POW_W-1:0] power;
  } pw_rsp_t;

  typedef enum logic [2:0] {
    S_CLR, S_IDLE, S_CHK, S_ADD, S_QRD, S_QSTART, S_QPOW, S_QOUT
  } seq_state_t;

  typedef enum logic [1:0] {
    PW_IDLE, PW_MUL, PW_DIV
  } pw_state_t;

  typedef logic [QTR:0][SIN_W-1:0] lut_t;

  // Long division used only while the table is built at elaboration.
  function automatic longint unsigned div_u64(longint unsigned num, longint unsigned den);
    longint unsigned q;
    longint unsigned r;
    q = '0;
    r = '0;
    for (int b = 63; b >= 0; b--) begin
      r = {r[62:0], num[b]};
      if (r >= den) begin
        r    = r - den;
        q[b] = 1'b1;
      end
    end
    return q;
  endfunction

  // Quarter-wave sine in Q1.15 from a Taylor series in Q30, evaluated at elaboration.
  function automatic lut_t build_sine_lut();
    lut_t lut;
    longint unsigned x;
    longint unsigned x2;
    longint unsigned t;
    longint unsigned s;
    longint unsigned v;
    lut = '0;
    for (int j = 0; j <= QTR; j++) begin
      x  = (longint'(j) * 64'd1686629713 + 64'(HALF_QTR)) >> SINE_TABLE_BITS;
      x2 = (x * x + (64'd1 << 29)) >> 30;
      t  = 64'd1 << 30;
      for (int m = 8; m >= 1; m--) begin
        t = (64'd1 << 30) - div_u64((x2 * t) >> 30, 64'((2 * m) * (2 * m + 1)));
      end
      s = (x * t) >> 30;
      v = (s + (64'd1 << 14)) >> 15;
      if (v > 64'd32767) v = 64'd32767;
      lut[j] = v[SIN_W-1:0];
    end
    return lut;
  endfunction

  localparam lut_t SINE_LUT = build_sine_lut();

endpackage

### rtl/core/z2n_sine_rom.sv
// Two-port registered sine/cosine lookup over the quarter-wave table.
// Depends on z2n_pkg for the table and widths.
`timescale 1ns / 1ps
module z2n_sine_rom (
  input  logic                            clk,
  input  logic [z2n_pkg::IDX_W-1:0]       idx_a,
  input  logic [z2n_pkg::IDX_W-1:0]       idx_b,
  output logic signed [z2n_pkg::SIN_W-1:0] val_a,
  output logic signed [z2n_pkg::SIN_W-1:0] val_b
);
  import z2n_pkg::*;

  logic [QA_W-1:0]  addr_a, addr_b;
  logic [SIN_W-1:0] mag_a, mag_b;

  // Mirror in odd quadrants, negate in the lower half cycle.
  always_comb begin
    addr_a = idx_a[IDX_W-2] ? QA_W'(QTR) - {1'b0, idx_a[SINE_TABLE_BITS-1:0]}
                            : {1'b0, idx_a[SINE_TABLE_BITS-1:0]};
    addr_b = idx_b[IDX_W-2] ? QA_W'(QTR) - {1'b0, idx_b[SINE_TABLE_BITS-1:0]}
                            : {1'b0, idx_b[SINE_TABLE_BITS-1:0]};
    mag_a  = SINE_LUT[addr_a];
    mag_b  = SINE_LUT[addr_b];
  end

  always_ff @(posedge clk) begin
    val_a <= idx_a[IDX_W-1] ? -signed'(mag_a) : signed'(mag_a);
    val_b <= idx_b[IDX_W-1] ? -signed'(mag_b) : signed'(mag_b);
  end

endmodule

### rtl/core/z2n_power_unit.sv
// Iterative power unit: S^2+C^2 on one shared 18x18 multiplier, then restoring division.
// Depends on z2n_pkg for request/response structs and widths.
`timescale 1ns / 1ps
module z2n_power_unit (
  input  logic              clk,
  input  logic              rst_n,
  input  z2n_pkg::pw_req_t  req,
  output z2n_pkg::pw_rsp_t  rsp
);
  import z2n_pkg::*;

  pw_state_t st_r, st_nxt;
  logic [SUM_W-1:0]      as_r, ac_r;
  logic [COUNT_BITS-1:0] cnt_r;
  logic [2:0]            mstep_r;
  logic [DSTEP_W-1:0]    dstep_r;
  logic [SUM_W-1:0]      prod_r;
  logic [5:0]            sh_r;
  logic [ACC_W-1:0]      acc_r;
  logic [DVD_W-1:0]      dq_r;
  logic [REM_W-1:0]      rem_r;
  logic                  done_r;
  logic [POW_W-1:0]      power_r;

  logic [SUM_W-1:0]  opnd;
  logic [HALF_W-1:0] mul_a, mul_b;
  logic [5:0]        sh_nxt;
  logic [ACC_W-1:0]  acc_sum;
  logic [REM_W-1:0]  rem_sh;
  logic              ge;
  logic [DVD_W-1:0]  dq_nxt;

  always_comb begin
    st_nxt = st_r;
    unique case (st_r)
      PW_IDLE: if (req.start) st_nxt = PW_MUL;
      PW_MUL:  if (mstep_r == 3'd6) st_nxt = PW_DIV;
      PW_DIV:  if (dstep_r == DSTEP_W'(DVD_W - 1)) st_nxt = PW_IDLE;
      default: st_nxt = PW_IDLE;
    endcase
  end

  always_comb begin
    opnd   = (mstep_r < 3'd3) ? as_r : ac_r;
    mul_a  = '0;
    mul_b  = '0;
    sh_nxt = '0;
    unique case (mstep_r)
      3'd0, 3'd3: begin
        mul_a = opnd[HALF_W-1:0];
        mul_b = opnd[HALF_W-1:0];
      end
      3'd1, 3'd4: begin
        mul_a  = opnd[SUM_W-1:HALF_W];
        mul_b  = opnd[HALF_W-1:0];
        sh_nxt = 6'(HALF_W + 1);
      end
      3'd2, 3'd5: begin
        mul_a  = opnd[SUM_W-1:HALF_W];
        mul_b  = opnd[SUM_W-1:HALF_W];
        sh_nxt = 6'(SUM_W);
      end
      default: ;
    endcase
    acc_sum = (mstep_r != 3'd0) ? acc_r + ({{SUM_W{1'b0}}, prod_r} << sh_r) : acc_r;
    rem_sh  = {rem_r[REM_W-2:0], dq_r[DVD_W-1]};
    ge      = rem_sh >= {1'b0, cnt_r};
    dq_nxt  = {dq_r[DVD_W-2:0], ge};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r   <= PW_IDLE;
      done_r <= 1'b0;
    end else begin
      st_r   <= st_nxt;
      done_r <= (st_r == PW_DIV) && (dstep_r == DSTEP_W'(DVD_W - 1));
    end
  end

  always_ff @(posedge clk) begin
    unique case (st_r)
      PW_IDLE: begin
        as_r    <= req.sin_sum[SUM_W-1] ? SUM_W'(-req.sin_sum) : SUM_W'(req.sin_sum);
        ac_r    <= req.cos_sum[SUM_W-1] ? SUM_W'(-req.cos_sum) : SUM_W'(req.cos_sum);
        cnt_r   <= req.count;
        mstep_r <= '0;
        acc_r   <= '0;
      end
      PW_MUL: begin
        prod_r  <= mul_a * mul_b;
        sh_r    <= sh_nxt;
        acc_r   <= acc_sum;
        mstep_r <= mstep_r + 3'd1;
        // hand the scaled sum to the divider
        dq_r    <= acc_sum[ACC_W-2:POW_SHIFT];
        rem_r   <= '0;
        dstep_r <= '0;
      end
      PW_DIV: begin
        rem_r   <= ge ? rem_sh - {1'b0, cnt_r} : rem_sh;
        dq_r    <= dq_nxt;
        dstep_r <= dstep_r + DSTEP_W'(1);
        if (dstep_r == DSTEP_W'(DVD_W - 1)) begin
          power_r <= (|dq_nxt[DVD_W-1:POW_W]) ? {POW_W{1'b1}} : dq_nxt[POW_W-1:0];
        end
      end
      default: ;
    endcase
  end

  assign rsp.done  = done_r;
  assign rsp.power = power_r;

endmodule

### rtl/core/z2n_harmonic_power_accumulator.sv
// Top level of the Z^2_n harmonic power accumulator; instantiates z2n_sine_rom and
// z2n_power_unit and holds the sum and count memories. Depends on z2n_pkg.
`timescale 1ns / 1ps
// Usage: after reset the block clears its 2048-entry sum memories, one slot per cycle,
// and holds in_stall high meanwhile; configuration writes are taken at any time. One
// request is handled at a time. An add request (opcode 0) walks the eight harmonics
// through the sine table and the sum memories' read-modify-write path, one harmonic
// per cycle, and holds in_stall until the walk is done. A query request (opcode 1)
// passes the trial check and returns one result per harmonic in use; for each result
// the block reads the sums, starts the power unit, forms S^2+C^2 on the unit's shared
// 18x18 multiplier, runs one-bit restoring division by the event count, takes the
// quotient and presents the result, then waits for the result to be taken. An empty
// trial skips the power unit and answers with a zero power.
module z2n_harmonic_power_accumulator (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  z2n_pkg::in_req_t            in_req,
  output logic                        out_valid,
  input  logic                        out_stall,
  output z2n_pkg::out_rsp_t           out_rsp,
  input  logic                        cfg_wr_en,
  input  logic [z2n_pkg::HN_W-1:0]    cfg_wr_data
);
  import z2n_pkg::*;

  seq_state_t state_r, state_nxt;

  in_req_t               req_r;
  logic [HN_W-1:0]       harm_r;
  logic [HN_W-1:0]       n_r;
  logic [HN_W-1:0]       k_r;
  logic [SLOT_W-1:0]     clr_r;
  logic [PHASE_BITS-1:0] angle_r;
  logic                  p_r;
  logic [SLOT_W-1:0]     p_slot_r;
  logic [COUNT_BITS-1:0] cnt_q_r;
  logic [POW_W-1:0]      total_r;
  out_rsp_t              out_rsp_r;

  logic signed [SUM_W-1:0] sin_mem [NUM_SLOTS];
  logic signed [SUM_W-1:0] cos_mem [NUM_SLOTS];
  logic [COUNT_BITS-1:0]   cnt_mem [NUM_TRIALS];
  logic signed [SUM_W-1:0] sin_rd_r, cos_rd_r;
  logic [COUNT_BITS-1:0]   cnt_rd_r;

  logic signed [SIN_W-1:0] rom_sin, rom_cos;
  logic [IDX_W-1:0]        idx_sin, idx_cos;

  pw_req_t pw_req;
  pw_rsp_t pw_rsp;

  logic              accept;
  logic              trial_ok;
  logic              cnt_full;
  logic [SLOT_W-1:0] rd_slot;
  logic              sum_we;
  logic [SLOT_W-1:0] sum_wa;
  logic signed [SUM_W-1:0] sin_wd, cos_wd;
  logic              cnt_we;
  logic [TRIAL_AW-1:0] cnt_wa;
  logic [COUNT_BITS-1:0] cnt_wd;
  logic              issue;
  logic              load_out;
  logic [POW_W-1:0]  power_v;
  logic [POW_W:0]    total_sum;
  logic [POW_W-1:0]  total_v;
  logic [HN_W-1:0]   n_v;
  logic [HN_W-1:0]   k_next;

  assign accept   = in_valid && !in_stall;
  assign in_stall = (state_r != S_IDLE);
  assign out_valid = (state_r == S_QOUT);
  assign out_rsp  = out_rsp_r;

  assign trial_ok = {1'b0, req_r.trial_index} < (TRIAL_W + 1)'(NUM_TRIALS);
  assign cnt_full = (cnt_rd_r == {COUNT_BITS{1'b1}});
  assign rd_slot  = {req_r.trial_index[TRIAL_AW-1:0], k_r[HK_W-1:0]};
  assign issue    = (state_r == S_ADD) && (k_r != HN_W'(MAX_HARMONICS));
  assign k_next   = k_r + HN_W'(1);

  // Angle of harmonic k is k*phase; index the table with its top bits.
  assign idx_sin = angle_r[PHASE_BITS-1 -: IDX_W];
  assign idx_cos = idx_sin + IDX_W'(QTR);

  z2n_sine_rom u_rom (
    .clk   (clk),
    .idx_a (idx_sin),
    .idx_b (idx_cos),
    .val_a (rom_sin),
    .val_b (rom_cos)
  );

  assign pw_req.start   = (state_r == S_QSTART) && (cnt_q_r != '0);
  assign pw_req.sin_sum = sin_rd_r;
  assign pw_req.cos_sum = cos_rd_r;
  assign pw_req.count   = cnt_q_r;

  z2n_power_unit u_pow (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (pw_req),
    .rsp   (pw_rsp)
  );

  // Clamp the harmonic count register into 1..MAX_HARMONICS.
  always_comb begin
    priority if (harm_r == '0) n_v = HN_W'(1);
    else if (harm_r > HN_W'(MAX_HARMONICS)) n_v = HN_W'(MAX_HARMONICS);
    else n_v = harm_r;
  end

  // Memory write sources: clearing pass, or the read-modify-write of an add.
  always_comb begin
    sum_we = 1'b0;
    sum_wa = p_slot_r;
    sin_wd = sin_rd_r + SUM_W'(rom_sin);
    cos_wd = cos_rd_r + SUM_W'(rom_cos);
    cnt_we = 1'b0;
    cnt_wa = req_r.trial_index[TRIAL_AW-1:0];
    cnt_wd = cnt_q_r + COUNT_BITS'(1);
    if (state_r == S_CLR) begin
      sum_we = 1'b1;
      sum_wa = clr_r;
      sin_wd = '0;
      cos_wd = '0;
      cnt_we = 1'b1;
      cnt_wa = clr_r[SLOT_W-1:HK_W];
      cnt_wd = '0;
    end else if (p_r) begin
      sum_we = 1'b1;
    end
    if (state_r == S_ADD && !issue) cnt_we = 1'b1;
  end

  // Result assembly: power of this harmonic and the saturating running sum.
  always_comb begin
    load_out  = ((state_r == S_QSTART) && (cnt_q_r == '0)) ||
                ((state_r == S_QPOW) && pw_rsp.done);
    power_v   = (cnt_q_r == '0) ? '0 : pw_rsp.power;
    total_sum = {1'b0, total_r} + {1'b0, power_v};
    total_v   = total_sum[POW_W] ? {POW_W{1'b1}} : total_sum[POW_W-1:0];
  end

  // Sequencer next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_CLR:    if (clr_r == {SLOT_W{1'b1}}) state_nxt = S_IDLE;
      S_IDLE:   if (accept) state_nxt = S_CHK;
      S_CHK: begin
        if (req_r.opcode == OP_QUERY) state_nxt = S_QRD;
        else if (!trial_ok || cnt_full) state_nxt = S_IDLE;
        else state_nxt = S_ADD;
      end
      S_ADD:    if (!issue) state_nxt = S_IDLE;
      S_QRD:    state_nxt = S_QSTART;
      S_QSTART: state_nxt = (cnt_q_r == '0) ? S_QOUT : S_QPOW;
      S_QPOW:   if (pw_rsp.done) state_nxt = S_QOUT;
      S_QOUT: begin
        if (!out_stall) state_nxt = out_rsp_r.last ? S_IDLE : S_QRD;
      end
      default:  state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLR;
      clr_r   <= '0;
      harm_r  <= HARM_RESET;
      p_r     <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (state_r == S_CLR) clr_r <= clr_r + SLOT_W'(1);
      if (cfg_wr_en) harm_r <= cfg_wr_data;
      p_r <= issue;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      req_r   <= in_req;
      angle_r <= in_req.phase;
    end
    if (state_r == S_CHK) begin
      k_r     <= '0;
      n_r     <= n_v;
      total_r <= '0;
      cnt_q_r <= (req_r.opcode == OP_ADD || trial_ok) ? cnt_rd_r : '0;
    end
    if (issue) begin
      k_r      <= k_next;
      angle_r  <= angle_r + req_r.phase;
      p_slot_r <= rd_slot;
    end
    if (load_out) begin
      total_r                    <= total_v;
      out_rsp_r.harmonic_number  <= k_next;
      out_rsp_r.harmonic_power   <= power_v;
      out_rsp_r.cumulative_power <= total_v;
      out_rsp_r.event_count      <= cnt_q_r;
      out_rsp_r.no_events        <= (cnt_q_r == '0);
      out_rsp_r.last             <= (k_next == n_r);
    end
    if (state_r == S_QOUT && !out_stall && !out_rsp_r.last) k_r <= k_next;
  end

  // Sum memories: one write port, one registered read port each.
  always_ff @(posedge clk) begin
    if (sum_we) begin
      sin_mem[sum_wa] <= sin_wd;
      cos_mem[sum_wa] <= cos_wd;
    end
    sin_rd_r <= sin_mem[rd_slot];
    cos_rd_r <= cos_mem[rd_slot];
  end

  // Count memory: read at the incoming request's trial so the count is ready in S_CHK.
  always_ff @(posedge clk) begin
    if (cnt_we) cnt_mem[cnt_wa] <= cnt_wd;
    cnt_rd_r <= cnt_mem[in_req.trial_index[TRIAL_AW-1:0]];
  end

  a_busy_while_output: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> in_stall) else $error("input taken while a result is pending");

  a_one_request: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> in_stall) else $error("second request taken during processing");

  a_last_matches_n: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_rsp.last) |-> (out_rsp.harmonic_number == n_r))
    else $error("last mark on wrong harmonic");

  a_sum_covers_power: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_rsp.cumulative_power >= out_rsp.harmonic_power))
    else $error("running sum below harmonic power");

endmodule
